>>> rtl/acbc_pkg.sv
`default_nettype none
package acbc_pkg;

    localparam int KEY_BITS     = 256;
    localparam int BLK_BITS     = 128;
    localparam int RK_ROWS      = 15;
    localparam int RK_AW        = 4;
    localparam int CFG_AW       = 3;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_KEY_A    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_KEY_B    = 3'd1;
    localparam logic [CFG_AW-1:0] REG_KEY_C    = 3'd2;
    localparam logic [CFG_AW-1:0] REG_KEY_D    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_KEY_SIZE = 3'd4;
    localparam logic [CFG_AW-1:0] REG_DIR      = 3'd5;
    localparam logic [CFG_AW-1:0] REG_IV_HIGH  = 3'd6;
    localparam logic [CFG_AW-1:0] REG_IV_LOW   = 3'd7;

    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEXP,
        S_PRE,
        S_ARK,
        S_ROUND,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             en;
        logic [RK_AW-1:0] addr;
        logic [127:0]     data;
    } t_rk_wr;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Multiply by x in GF(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]],
                    FWD_SBOX[w[15:8]],  FWD_SBOX[w[7:0]]};
    endfunction

    // Key length in 32-bit words; size three runs as a 256-bit key
    function automatic logic [3:0] key_words(input logic [1:0] ks);
        case (ks)
            KEY_128: key_words = 4'd4;
            KEY_192: key_words = 4'd6;
            default: key_words = 4'd8;
        endcase
    endfunction

endpackage
`default_nettype wire

>>> rtl/acbc_blk_if.sv
`default_nettype none
interface acbc_blk_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;

    modport source (output valid, block_high, block_low, first_block, input ready);
    modport sink (input valid, block_high, block_low, first_block, output ready);
endinterface
`default_nettype wire

>>> rtl/acbc_res_if.sv
`default_nettype none
interface acbc_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;

    modport source (output valid, result_high, result_low, input ready);
    modport sink (input valid, result_high, result_low, output ready);
endinterface
`default_nettype wire

>>> rtl/acbc_cfg_if.sv
`default_nettype none
interface acbc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/acbc_ram.sv
`default_nettype none
module acbc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/acbc_key_exp.sv
`default_nettype none
module acbc_key_exp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [acbc_pkg::KEY_BITS-1:0] i_key,
    input  wire logic [3:0]                   i_nk,
    output logic                              o_busy,
    output logic                              o_done,
    output acbc_pkg::t_rk_wr                  o_wr
);
    import acbc_pkg::*;

    logic        r_busy;
    logic [5:0]  r_i;
    logic [2:0]  r_km;
    logic [7:0]  r_rcon;
    logic [31:0] r_win [8];
    logic [95:0] r_row;
    logic [3:0]  r_nk;

    logic [31:0] w_tmp;
    logic [31:0] w_new;
    logic [5:0]  w_total;
    logic [2:0]  w_far;

    assign w_total = {r_nk + 4'd7, 2'b00};
    assign w_far   = 3'(r_nk - 4'd1);

    // Produce one schedule word per beat
    always_comb begin
        w_tmp = r_win[0];
        if (r_km == 3'd0) begin
            w_tmp = sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rcon, 24'd0};
        end else if (r_nk == 4'd8 && r_km == 3'd4) begin
            w_tmp = sub_word(r_win[0]);
        end
        if (r_i < {2'b00, r_nk}) begin
            w_new = i_key[KEY_BITS-1 - 32*r_i[2:0] -: 32];
        end else begin
            w_new = r_win[w_far] ^ w_tmp;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_busy && (r_i == w_total - 6'd1);
    assign o_wr.en    = r_busy && (r_i[1:0] == 2'b11);
    assign o_wr.addr  = r_i[5:2];
    assign o_wr.data  = {r_row, w_new};

    // Control: busy flag set on start and cleared when done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    // Datapath: window, row gather, round constant
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i    <= '0;
            r_km   <= '0;
            r_rcon <= 8'h01;
            r_nk   <= i_nk;
        end else if (r_busy) begin
            r_i   <= r_i + 6'd1;
            r_km  <= ({1'b0, r_km} == r_nk - 4'd1) ? 3'd0 : r_km + 3'd1;
            r_row <= {r_row[63:0], w_new};
            if (r_i >= {2'b00, r_nk} && r_km == 3'd0) begin
                r_rcon <= xtime(r_rcon);
            end
            r_win[0] <= w_new;
            for (int k = 1; k < 8; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/acbc_round.sv
`default_nettype none
module acbc_round (
    input  wire logic [127:0] i_state,
    input  wire logic [127:0] i_rk,
    input  wire logic         i_dec,
    input  wire logic         i_last,
    output logic      [127:0] o_state
);
    import acbc_pkg::*;

    function automatic logic [7:0] mul9(input logic [7:0] b);
        mul9 = xtime(xtime(xtime(b))) ^ b;
    endfunction
    function automatic logic [7:0] mul11(input logic [7:0] b);
        mul11 = xtime(xtime(xtime(b))) ^ xtime(b) ^ b;
    endfunction
    function automatic logic [7:0] mul13(input logic [7:0] b);
        mul13 = xtime(xtime(xtime(b))) ^ xtime(xtime(b)) ^ b;
    endfunction
    function automatic logic [7:0] mul14(input logic [7:0] b);
        mul14 = xtime(xtime(xtime(b))) ^ xtime(xtime(b)) ^ xtime(b);
    endfunction

    logic [7:0] b_in [16];
    logic [7:0] b_k  [16];
    logic [7:0] b_a  [16];
    logic [7:0] b_b  [16];
    logic [7:0] b_o  [16];

    // One cipher or inverse-cipher round; i_last selects the final round without mixing
    always_comb begin
        for (int k = 0; k < 16; k++) begin
            b_in[k] = i_state[127 - 8*k -: 8];
            b_k[k]  = i_rk[127 - 8*k -: 8];
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (i_dec) begin
                    b_a[r + 4*((c + r) % 4)] = b_in[r + 4*c];
                end else begin
                    b_a[r + 4*c] = FWD_SBOX[b_in[r + 4*((c + r) % 4)]];
                end
            end
        end
        for (int k = 0; k < 16; k++) begin
            b_b[k] = i_dec ? (INV_SBOX[b_a[k]] ^ b_k[k]) : b_a[k];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (i_last) begin
                    b_o[4*c + r] = b_b[4*c + r];
                end else if (i_dec) begin
                    b_o[4*c + r] = mul14(b_b[4*c + r])           ^
                                   mul11(b_b[4*c + (r + 1) % 4]) ^
                                   mul13(b_b[4*c + (r + 2) % 4]) ^
                                   mul9(b_b[4*c + (r + 3) % 4]);
                end else begin
                    b_o[4*c + r] = xtime(b_b[4*c + r]) ^
                                   xtime(b_b[4*c + (r + 1) % 4]) ^ b_b[4*c + (r + 1) % 4] ^
                                   b_b[4*c + (r + 2) % 4] ^ b_b[4*c + (r + 3) % 4];
                end
            end
        end
        for (int k = 0; k < 16; k++) begin
            o_state[127 - 8*k -: 8] = i_dec ? b_o[k] : (b_o[k] ^ b_k[k]);
        end
    end
endmodule
`default_nettype wire

>>> rtl/aes_cbc_block_cipher.sv
`default_nettype none
// Sequence: load, initial round key addition, then nr rounds (nr = 10, 12 or 14),
// preceded by key expansion on the first block after a key change.
// Input: a new block is accepted only when idle; one round per cycle through a shared
// round unit, gated by the single read port of the round key memory.
// Reset: synchronous, active low; clears chain value, keys_ready and handshakes.
module aes_cbc_block_cipher (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    acbc_blk_if.sink   i_blk,
    acbc_res_if.source o_res,
    acbc_cfg_if.sink   i_cfg
);
    import acbc_pkg::*;

    t_state       r_state, n_state;
    logic [63:0]  r_key_a, r_key_b, r_key_c, r_key_d;
    logic [1:0]   r_key_size;
    logic         r_dir;
    logic [63:0]  r_iv_high, r_iv_low;
    logic [127:0] r_chain;
    logic         r_keys_ready;
    logic [3:0]   r_nr;
    logic [127:0] r_blk;
    logic [127:0] r_cv;
    logic [127:0] r_s;
    logic         r_dec;
    logic [3:0]   r_step;
    logic         r_ov;
    logic [127:0] r_out;

    logic         w_in_acc;
    logic         w_kexp_start;
    logic         w_kexp_busy;
    logic         w_kexp_done;
    t_rk_wr       w_rk_wr;
    logic [RK_AW-1:0] w_raddr;
    logic [127:0] w_rk;
    logic [127:0] w_round;
    logic         w_last;
    logic [127:0] w_cv_use;
    logic         w_slot_free;

    assign i_cfg.ready       = 1'b1;
    assign i_blk.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_ov;
    assign o_res.result_high = r_out[127:64];
    assign o_res.result_low  = r_out[63:0];

    assign w_in_acc    = i_blk.valid && i_blk.ready;
    assign w_cv_use    = i_blk.first_block ? {r_iv_high, r_iv_low} : r_chain;
    assign w_last      = (r_step == r_nr + 4'd1);
    assign w_slot_free = !r_ov || o_res.ready;

    // Round key schedule, one word per cycle
    acbc_key_exp u_key_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_kexp_start),
        .i_key   ({r_key_a, r_key_b, r_key_c, r_key_d}),
        .i_nk    (key_words(r_key_size)),
        .o_busy  (w_kexp_busy),
        .o_done  (w_kexp_done),
        .o_wr    (w_rk_wr)
    );

    acbc_ram #(.WIDTH(BLK_BITS), .DEPTH(RK_ROWS)) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (w_rk_wr.en),
        .i_waddr (w_rk_wr.addr),
        .i_wdata (w_rk_wr.data),
        .i_raddr (w_raddr),
        .o_rdata (w_rk)
    );

    acbc_round u_round (
        .i_state (r_s),
        .i_rk    (w_rk),
        .i_dec   (r_dec),
        .i_last  (w_last),
        .o_state (w_round)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, key expansion start and key row address
    always_comb begin
        n_state      = r_state;
        w_kexp_start = 1'b0;
        w_raddr      = '0;
        if (r_step <= r_nr) begin
            w_raddr = r_dec ? (r_nr - r_step) : r_step;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state      = r_keys_ready ? S_PRE : S_KEXP;
                    w_kexp_start = !r_keys_ready;
                end
            end
            S_KEXP: begin
                if (w_kexp_done) begin
                    n_state = S_PRE;
                end
            end
            S_PRE:   n_state = S_ARK;
            S_ARK:   n_state = S_ROUND;
            S_ROUND: begin
                if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration registers and key status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_a      <= '0;
            r_key_b      <= '0;
            r_key_c      <= '0;
            r_key_d      <= '0;
            r_key_size   <= KEY_128;
            r_dir        <= 1'b0;
            r_iv_high    <= '0;
            r_iv_low     <= '0;
            r_keys_ready <= 1'b0;
            r_nr         <= 4'd10;
        end else begin
            if (w_kexp_start) begin
                r_nr <= key_words(r_key_size) + 4'd6;
            end
            if (w_kexp_done) begin
                r_keys_ready <= 1'b1;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_KEY_A:    begin r_key_a <= i_cfg.data; r_keys_ready <= 1'b0; end
                    REG_KEY_B:    begin r_key_b <= i_cfg.data; r_keys_ready <= 1'b0; end
                    REG_KEY_C:    begin r_key_c <= i_cfg.data; r_keys_ready <= 1'b0; end
                    REG_KEY_D:    begin r_key_d <= i_cfg.data; r_keys_ready <= 1'b0; end
                    REG_KEY_SIZE: begin
                        r_key_size   <= i_cfg.data[1:0];
                        r_keys_ready <= 1'b0;
                    end
                    REG_DIR:      r_dir     <= i_cfg.data[0];
                    REG_IV_HIGH:  r_iv_high <= i_cfg.data;
                    REG_IV_LOW:   r_iv_low  <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    // Chain value and output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (w_in_acc && i_blk.first_block) begin
                r_chain <= {r_iv_high, r_iv_low};
            end
            if (r_state == S_DONE && w_slot_free) begin
                r_ov    <= 1'b1;
                r_chain <= r_dec ? r_blk : r_s;
            end
        end
    end

    // Block datapath: load, round steps, result
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_blk  <= {i_blk.block_high, i_blk.block_low};
                    r_cv   <= w_cv_use;
                    r_dec  <= r_dir;
                    r_s    <= r_dir ? {i_blk.block_high, i_blk.block_low}
                                    : ({i_blk.block_high, i_blk.block_low} ^ w_cv_use);
                end
                r_step <= '0;
            end
            S_PRE: r_step <= 4'd1;
            S_ARK: begin
                r_s    <= r_s ^ w_rk;
                r_step <= 4'd2;
            end
            S_ROUND: begin
                r_s    <= w_round;
                r_step <= r_step + 4'd1;
            end
            S_DONE: begin
                if (w_slot_free) begin
                    r_out <= r_dec ? (r_s ^ r_cv) : r_s;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_keys_ready_in_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> r_keys_ready)
        else $error("round step without a valid key schedule");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_step >= 4'd2 && r_step <= r_nr + 4'd1))
        else $error("round step out of range");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside completion");

    a_kexp_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_kexp_busy |-> (r_state == S_KEXP))
        else $error("key expansion running outside its state");
`endif
endmodule
`default_nettype wire
